FILE: sv/shmm_pkg.sv
// Shared types, constants and helpers for the size histogram block.
`timescale 1ns / 1ps

package shmm_pkg;

	localparam int BIN_COUNT_DEF   = 128;
	localparam int COUNT_WIDTH_DEF = 16;
	localparam int FONT_W          = 13;
	localparam int SIZE_W          = 8;
	localparam int TOTAL_W         = 32;
	localparam int BIN_CALC_W      = 10;
	localparam logic [SIZE_W-1:0] DEFAULT_SIZE_RST = 8'd12;
	localparam logic [FONT_W:0]   ROUND_HALF       = 14'd8;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD,
		ST_WAIT,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic clr;
		logic accept;
		logic upd;
		logic start;
		logic scan;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic last_s1;
		logic ptr_last;
		logic out_busy;
	} stat_t;

	function automatic logic [SIZE_W-1:0] clip8(input logic [BIN_CALC_W-1:0] idx);
		logic [SIZE_W-1:0] res;
		if (idx > BIN_CALC_W'(255)) begin
			res = 8'hFF;
		end else begin
			res = idx[SIZE_W-1:0];
		end
		return res;
	endfunction

endpackage

FILE: sv/size_histogram_mode_median_top.sv
// Top level of the font size histogram with per-page mode and median.
//
//  Channel   Signals                           Role
//  s_axis    s_tvalid s_tready s_tdata s_tlast  font size samples, tlast ends page
//  m_axis    m_tvalid m_tready m_tdata          one result per page
//  cfg       cfg_valid cfg_ready cfg_data       default size register
//
//  A sample first reads its bin, then writes back the saturated count.
//  The page-ending sample then starts one sweep over the bin memory, which
//  reads each bin for mode and median and writes it back to zero.
//  After reset a clearing pass over every bin runs before samples are taken.
//  A result waits in its output register; a new page end stalls until it is taken.
`timescale 1ns / 1ps

module size_histogram_mode_median_top #(
	parameter int BIN_COUNT   = shmm_pkg::BIN_COUNT_DEF,
	parameter int COUNT_WIDTH = shmm_pkg::COUNT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [12:0] font_size, [15:13] zero
	input  logic        s_tlast,   // last_sample
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [7:0] body_size, [15:8] median_size, [47:16] sample_count
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);

	shmm_pkg::cmd_t  cmd;
	shmm_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	shmm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	shmm_datapath #(
		.BIN_COUNT   (BIN_COUNT),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.font_size   (s_tdata[shmm_pkg::FONT_W-1:0]),
		.last_sample (s_tlast),
		.cfg_wr      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata)
	);

endmodule

FILE: sv/shmm_ctrl.sv
// Controller state machine for the size histogram block.
`timescale 1ns / 1ps

module shmm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  shmm_pkg::stat_t stat,
	output shmm_pkg::cmd_t  cmd
);

	shmm_pkg::state_t state_q, state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shmm_pkg::ST_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			shmm_pkg::ST_CLEAR: begin
				if (stat.ptr_last) state_n = shmm_pkg::ST_IDLE;
			end
			shmm_pkg::ST_IDLE: begin
				if (s_tvalid) state_n = shmm_pkg::ST_UPD;
			end
			shmm_pkg::ST_UPD: begin
				if (!stat.last_s1) begin
					state_n = shmm_pkg::ST_IDLE;
				end else if (stat.out_busy) begin
					state_n = shmm_pkg::ST_WAIT;
				end else begin
					state_n = shmm_pkg::ST_SCAN;
				end
			end
			shmm_pkg::ST_WAIT: begin
				if (!stat.out_busy) state_n = shmm_pkg::ST_SCAN;
			end
			shmm_pkg::ST_SCAN: begin
				if (stat.ptr_last) state_n = shmm_pkg::ST_FINISH;
			end
			shmm_pkg::ST_FINISH: begin
				state_n = shmm_pkg::ST_IDLE;
			end
			default: state_n = shmm_pkg::ST_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			shmm_pkg::ST_CLEAR: begin
				cmd.clr = 1'b1;
			end
			shmm_pkg::ST_IDLE: begin
				s_tready   = 1'b1;
				cmd.accept = s_tvalid;
			end
			shmm_pkg::ST_UPD: begin
				cmd.upd   = 1'b1;
				cmd.start = stat.last_s1 && !stat.out_busy;
			end
			shmm_pkg::ST_WAIT: begin
				cmd.start = !stat.out_busy;
			end
			shmm_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			shmm_pkg::ST_FINISH: begin
				cmd.finish = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: sv/shmm_datapath.sv
// Datapath: bin memory, sample counter, mode and median scan, result register.
`timescale 1ns / 1ps

module shmm_datapath #(
	parameter int BIN_COUNT   = shmm_pkg::BIN_COUNT_DEF,
	parameter int COUNT_WIDTH = shmm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  shmm_pkg::cmd_t                    cmd,
	output shmm_pkg::stat_t                   stat,
	input  logic [shmm_pkg::FONT_W-1:0]       font_size,
	input  logic                              last_sample,
	input  logic                              cfg_wr,
	input  logic [shmm_pkg::SIZE_W-1:0]       cfg_data,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [2*shmm_pkg::SIZE_W+shmm_pkg::TOTAL_W-1:0] m_tdata
);

	localparam int IDX_W = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
	localparam int RUN_W = shmm_pkg::TOTAL_W + 1;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(BIN_COUNT - 1);

	logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];

	logic [shmm_pkg::SIZE_W-1:0]  default_size_q;
	logic [IDX_W-1:0]             ptr_q;
	logic                         valid_s1;
	logic                         last_s1;
	logic [IDX_W-1:0]             bin_s1;
	logic [COUNT_WIDTH-1:0]       rd_data_s1;
	logic                         rd_vld_s1;
	logic [IDX_W-1:0]             rd_idx_s1;
	logic [shmm_pkg::TOTAL_W-1:0] total_q;
	logic [COUNT_WIDTH-1:0]       best_cnt_q, best_cnt_n;
	logic [IDX_W-1:0]             mode_idx_q, mode_idx_n;
	logic [RUN_W-1:0]             run_q, run_n;
	logic                         found_q, found_n;
	logic [IDX_W-1:0]             med_idx_q, med_idx_n;
	logic                         m_tvalid_q;
	logic [shmm_pkg::SIZE_W-1:0]  body_q, median_q;
	logic [shmm_pkg::TOTAL_W-1:0] count_q;

	logic                            in_pos;
	logic [shmm_pkg::FONT_W:0]       round_sum;
	logic [shmm_pkg::BIN_CALC_W-1:0] bin_raw;
	logic [IDX_W-1:0]                bin_in;
	logic [IDX_W-1:0]                rd_addr;
	logic                            wr_en;
	logic [IDX_W-1:0]                wr_addr;
	logic [COUNT_WIDTH-1:0]          wr_data;
	logic [RUN_W-1:0]                run_sum;
	logic [shmm_pkg::SIZE_W-1:0]     body_n, median_n;

	always_comb begin
		in_pos    = !font_size[shmm_pkg::FONT_W-1] && (font_size != '0);
		round_sum = {1'b0, font_size} + shmm_pkg::ROUND_HALF;
		bin_raw   = round_sum[shmm_pkg::FONT_W:4];
		if (bin_raw > shmm_pkg::BIN_CALC_W'(BIN_COUNT - 1)) begin
			bin_in = IDX_LAST;
		end else begin
			bin_in = bin_raw[IDX_W-1:0];
		end
	end

	always_comb begin
		rd_addr = cmd.accept ? bin_in : ptr_q;
		wr_en   = cmd.clr || cmd.scan || (cmd.upd && valid_s1);
		wr_addr = cmd.upd ? bin_s1 : ptr_q;
		if (cmd.upd) begin
			wr_data = (rd_data_s1 == '1) ? rd_data_s1 : rd_data_s1 + COUNT_WIDTH'(1);
		end else begin
			wr_data = '0;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= mem[rd_addr];
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			bin_s1 <= bin_in;
		end
		rd_idx_s1 <= ptr_q;
	end

	always_comb begin
		best_cnt_n = best_cnt_q;
		mode_idx_n = mode_idx_q;
		run_n      = run_q;
		found_n    = found_q;
		med_idx_n  = med_idx_q;
		run_sum    = run_q + RUN_W'(rd_data_s1);
		if (rd_vld_s1) begin
			if (rd_data_s1 > best_cnt_q) begin
				best_cnt_n = rd_data_s1;
				mode_idx_n = rd_idx_s1;
			end
			if (!found_q) begin
				run_n = run_sum;
				if (run_sum > RUN_W'(total_q[shmm_pkg::TOTAL_W-1:1])) begin
					found_n   = 1'b1;
					med_idx_n = rd_idx_s1;
				end
			end
		end
		if (mode_idx_n == '0) begin
			body_n = default_size_q;
		end else begin
			body_n = shmm_pkg::clip8(shmm_pkg::BIN_CALC_W'(mode_idx_n));
		end
		if (med_idx_n == '0) begin
			median_n = body_n;
		end else begin
			median_n = shmm_pkg::clip8(shmm_pkg::BIN_CALC_W'(med_idx_n));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_cnt_q <= '0;
			mode_idx_q <= '0;
			run_q      <= '0;
			found_q    <= 1'b0;
			med_idx_q  <= '0;
		end else begin
			best_cnt_q <= best_cnt_n;
			mode_idx_q <= mode_idx_n;
			run_q      <= run_n;
			found_q    <= found_n;
			med_idx_q  <= med_idx_n;
		end
		if (cmd.finish) begin
			body_q   <= body_n;
			median_q <= median_n;
			count_q  <= total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_size_q <= shmm_pkg::DEFAULT_SIZE_RST;
			ptr_q          <= '0;
			valid_s1       <= 1'b0;
			last_s1        <= 1'b0;
			rd_vld_s1      <= 1'b0;
			total_q        <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (cfg_wr) begin
				default_size_q <= cfg_data;
			end
			if (cmd.start) begin
				ptr_q <= '0;
			end else if (cmd.clr || cmd.scan) begin
				ptr_q <= (ptr_q == IDX_LAST) ? '0 : ptr_q + IDX_W'(1);
			end
			if (cmd.accept) begin
				valid_s1 <= in_pos;
				last_s1  <= last_sample;
			end
			rd_vld_s1 <= cmd.scan;
			if (cmd.finish) begin
				total_q <= '0;
			end else if (cmd.upd && valid_s1 && (total_q != '1)) begin
				total_q <= total_q + shmm_pkg::TOTAL_W'(1);
			end
			if (cmd.finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign stat.last_s1  = last_s1;
	assign stat.ptr_last = (ptr_q == IDX_LAST);
	assign stat.out_busy = m_tvalid_q;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {count_q, median_q, body_q};

	a_rose_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(cmd.finish))
		else $error("result raised without a finished scan");

	a_start_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !m_tvalid_q)
		else $error("scan started while a result is pending");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= IDX_LAST)
		else $error("bin pointer beyond last bin");

	a_finish_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> $past(cmd.scan) && rd_vld_s1)
		else $error("finish without last scanned bin in flight");

endmodule

FILE: verif/size_histogram_mode_median_top_tb.sv
// Self-checking testbench for the font size histogram with per-page mode and median.
`timescale 1ns / 1ps

module size_histogram_mode_median_top_tb;

	import shmm_pkg::*;

	localparam int BINS        = BIN_COUNT_DEF;
	localparam int STALL_LIMIT = 20 * BINS + 2000;
	localparam int SETTLE      = BINS + 16;
	localparam logic [COUNT_WIDTH_DEF-1:0] BIN_FULL = {COUNT_WIDTH_DEF{1'b1}};

	typedef enum {PACE_FULL, PACE_SEND, PACE_RECV, PACE_BOTH} pace_t;
	typedef enum {ROW_CFG, ROW_SAMPLE} row_kind_t;

	typedef struct packed {
		logic [SIZE_W-1:0]  body;
		logic [SIZE_W-1:0]  median;
		logic [TOTAL_W-1:0] count;
	} metrics_t;

	typedef struct {
		row_kind_t         kind;
		logic [FONT_W-1:0] font;
		bit                end_page;
		logic [SIZE_W-1:0] cfg;
		bit                typed;
		metrics_t          want;
	} row_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata   = '0;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data  = '0;

	pace_t pace = PACE_FULL;

	logic [COUNT_WIDTH_DEF-1:0] bin_cnt [BINS];
	logic [TOTAL_W-1:0]         page_total;
	logic [SIZE_W-1:0]          dflt_size;

	metrics_t metrics_q [$];
	row_t     directed [$];
	int       mismatches  = 0;
	int       idle_cycles = 0;

	always #10 clk = ~clk;

	size_histogram_mode_median_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	task automatic page_model(input logic [FONT_W-1:0] font, input bit end_page,
			output bit emit, output metrics_t res);
		int              idx;
		int              mode_idx;
		int              med_idx;
		longint unsigned best_cnt;
		longint unsigned run;
		longint unsigned mid;
		bit              found;
		emit = 1'b0;
		res  = '0;
		if (!font[FONT_W-1] && font != '0) begin
			idx = (int'(font) + 8) >> 4;
			if (idx > BINS - 1) begin
				idx = BINS - 1;
			end
			if (bin_cnt[idx] != BIN_FULL) begin
				bin_cnt[idx] = bin_cnt[idx] + 1'b1;
			end
			if (page_total != '1) begin
				page_total = page_total + 1'b1;
			end
		end
		if (end_page) begin
			emit = 1'b1;
			if (page_total == '0) begin
				res.body   = dflt_size;
				res.median = dflt_size;
			end else begin
				mode_idx = 0;
				best_cnt = 0;
				med_idx  = 0;
				run      = 0;
				found    = 1'b0;
				mid      = page_total / 2;
				for (int i = 0; i < BINS; i++) begin
					if (bin_cnt[i] > best_cnt) begin
						best_cnt = bin_cnt[i];
						mode_idx = i;
					end
					run += bin_cnt[i];
					if (!found && run > mid) begin
						found   = 1'b1;
						med_idx = i;
					end
				end
				res.body   = (mode_idx == 0) ? dflt_size : ((mode_idx > 255) ? 8'hFF : 8'(mode_idx));
				res.median = (med_idx == 0) ? res.body : ((med_idx > 255) ? 8'hFF : 8'(med_idx));
			end
			res.count = page_total;
			foreach (bin_cnt[i]) begin
				bin_cnt[i] = '0;
			end
			page_total = '0;
		end
	endtask

	task automatic send_sample(input logic [FONT_W-1:0] font, input bit end_page,
			input bit typed, input metrics_t want);
		int       gap_pct;
		bit       emit;
		metrics_t res;
		gap_pct = (pace == PACE_SEND) ? 55 : ((pace == PACE_BOTH) ? 18 : 0);
		while ($urandom_range(99) < gap_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata  = {3'b000, font};
		s_tlast  = end_page;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		page_model(font, end_page, emit, res);
		if (emit) begin
			metrics_q.push_back(typed ? want : res);
		end
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic set_default(input logic [SIZE_W-1:0] value);
		while (metrics_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_data  = value;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		dflt_size = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic random_pages(input int n_items);
		int                sent;
		int                len;
		int                roll;
		int                pt;
		int                hot [3];
		logic [FONT_W-1:0] font;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(99) < 80) ? $urandom_range(1, 12) : $urandom_range(13, 60);
			foreach (hot[k]) begin
				hot[k] = ($urandom_range(9) == 0) ? $urandom_range(120, BINS - 1)
					: $urandom_range(1, 40);
			end
			for (int k = 0; k < len; k++) begin
				roll = $urandom_range(99);
				if (roll < 55) begin
					pt   = hot[$urandom_range(2)];
					font = FONT_W'(pt * 16 - 8 + $urandom_range(15));
				end else if (roll < 63) begin
					font = '0;
				end else if (roll < 73) begin
					font = 13'h1000 | FONT_W'($urandom_range(4095));
				end else if (roll < 81) begin
					font = FONT_W'($urandom_range(1, 15));
				end else if (roll < 89) begin
					font = FONT_W'($urandom_range(2024, 4095));
				end else begin
					font = FONT_W'($urandom);
				end
				send_sample(font, k == len - 1, 1'b0, '0);
			end
			sent += len;
			if ($urandom_range(9) == 0) begin
				while (metrics_q.size() != 0) begin
					@(negedge clk);
				end
			end
		end
	endtask

	function automatic row_t mk_row(row_kind_t kind, logic [FONT_W-1:0] font, bit end_page,
			logic [SIZE_W-1:0] cfg, bit typed, logic [SIZE_W-1:0] body,
			logic [SIZE_W-1:0] median, logic [TOTAL_W-1:0] count);
		row_t r;
		r.kind        = kind;
		r.font        = font;
		r.end_page    = end_page;
		r.cfg         = cfg;
		r.typed       = typed;
		r.want.body   = body;
		r.want.median = median;
		r.want.count  = count;
		return r;
	endfunction

	always @(negedge clk) begin
		case (pace)
			PACE_RECV: begin
				m_tready <= ($urandom_range(99) >= 55);
			end
			PACE_BOTH: begin
				m_tready <= ($urandom_range(99) >= 18);
			end
			default: begin
				m_tready <= 1'b1;
			end
		endcase
	end

	task automatic flag_field(input string field, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want_v, got_v);
			end
		end
	endtask

	always @(posedge clk) begin
		metrics_t want;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (metrics_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: unexpected result %h", $realtime, m_tdata);
				end
			end else begin
				want = metrics_q.pop_front();
				flag_field("body_size", 32'(want.body), 32'(m_tdata[7:0]));
				flag_field("median_size", 32'(want.median), 32'(m_tdata[15:8]));
				flag_field("sample_count", want.count, m_tdata[47:16]);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= STALL_LIMIT) begin
			$display("size_histogram_mode_median_top_tb failed");
			$finish;
		end
	end

	initial begin
		pace_t phases [4];
		foreach (bin_cnt[i]) begin
			bin_cnt[i] = '0;
		end
		page_total = '0;
		dflt_size  = DEFAULT_SIZE_RST;

		directed.push_back(mk_row(ROW_SAMPLE, 13'd0,    1, 0, 1, 12, 12, 0));
		directed.push_back(mk_row(ROW_SAMPLE, 13'h1000, 1, 0, 1, 12, 12, 0));
		directed.push_back(mk_row(ROW_SAMPLE, 13'd4095, 1, 0, 1, 127, 127, 1));
		directed.push_back(mk_row(ROW_SAMPLE, 13'd1,    1, 0, 1, 12, 12, 1));
		directed.push_back(mk_row(ROW_SAMPLE, 13'd7,    0, 0, 0, 0, 0, 0));
		directed.push_back(mk_row(ROW_SAMPLE, 13'd8,    1, 0, 0, 0, 0, 0));
		directed.push_back(mk_row(ROW_SAMPLE, 13'd24,   0, 0, 0, 0, 0, 0));
		directed.push_back(mk_row(ROW_SAMPLE, 13'd23,   0, 0, 0, 0, 0, 0));
		directed.push_back(mk_row(ROW_SAMPLE, 13'd40,   0, 0, 0, 0, 0, 0));
		directed.push_back(mk_row(ROW_SAMPLE, 13'd40,   1, 0, 0, 0, 0, 0));
		directed.push_back(mk_row(ROW_SAMPLE, 13'd192,  0, 0, 0, 0, 0, 0));
		directed.push_back(mk_row(ROW_SAMPLE, 13'h1FFF, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk_row(ROW_SAMPLE, 13'd2023, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk_row(ROW_SAMPLE, 13'd2039, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk_row(ROW_SAMPLE, 13'd2040, 0, 0, 0, 0, 0, 0));
		directed.push_back(mk_row(ROW_SAMPLE, 13'd192,  1, 0, 0, 0, 0, 0));
		directed.push_back(mk_row(ROW_CFG,    13'd0,    0, 0, 0, 0, 0, 0));
		directed.push_back(mk_row(ROW_SAMPLE, 13'd0,    1, 0, 1, 0, 0, 0));
		directed.push_back(mk_row(ROW_SAMPLE, 13'd3,    1, 0, 1, 0, 0, 1));
		directed.push_back(mk_row(ROW_CFG,    13'd0,    0, 255, 0, 0, 0, 0));
		directed.push_back(mk_row(ROW_SAMPLE, 13'd5,    1, 0, 1, 255, 255, 1));
		directed.push_back(mk_row(ROW_SAMPLE, 13'd4080, 1, 0, 1, 127, 127, 1));

		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[r]) begin
			if (directed[r].kind == ROW_CFG) begin
				set_default(directed[r].cfg);
			end else begin
				send_sample(directed[r].font, directed[r].end_page, directed[r].typed,
					directed[r].want);
			end
		end

		phases = '{PACE_FULL, PACE_SEND, PACE_RECV, PACE_BOTH};
		foreach (phases[p]) begin
			case (phases[p])
				PACE_FULL: set_default(8'd1);
				PACE_SEND: set_default(8'd255);
				PACE_RECV: set_default(8'($urandom_range(2, 254)));
				default:   set_default(DEFAULT_SIZE_RST);
			endcase
			pace = phases[p];
			random_pages(250);
		end

		while (metrics_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE) @(negedge clk);
		if (mismatches == 0) begin
			$display("size_histogram_mode_median_top_tb passed");
		end else begin
			$display("size_histogram_mode_median_top_tb failed");
		end
		$finish;
	end

endmodule
